[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dbd assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dbd assertion failed");

`endif

[hdl/dbd_pkg.sv]
`timescale 1ns / 1ps

package dbd_pkg;

    // Field widths
    localparam int DayW    = 5;
    localparam int MonW    = 4;
    localparam int YearW   = 14;
    localparam int DiffW   = 23;
    // Serial day number: 365 * 16383 + leap days + day of year fits in 23 bits unsigned
    localparam int SerialW = 24;
    localparam int DiffLimit = 3660000;

    typedef logic [DayW-1:0]    t_day;
    typedef logic [MonW-1:0]    t_month;
    typedef logic [YearW-1:0]   t_year;
    typedef logic [SerialW-1:0] t_serial;

    // Month codes
    localparam t_month MonJan = 4'd1;
    localparam t_month MonFeb = 4'd2;
    localparam t_month MonDec = 4'd12;

    // floor(q / 25) for q < 2^13, by reciprocal 5243 / 2^17 (exact in this range)
    function automatic logic [8:0] div25(input logic [12:0] q);
        logic [25:0] p;
        p = 26'(q) * 26'd5243;
        return p[25:17];
    endfunction

    // Days in month, common year
    function automatic t_day month_len(input t_month m);
        t_day len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month, common year
    function automatic logic [8:0] days_before(input t_month m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[hdl/dbd_serial.sv]
`timescale 1ns / 1ps

// Maps one date to its serial day number; flags an impossible date.
module dbd_serial
    import dbd_pkg::*;
(
    input  t_day    i_day,
    input  t_month  i_month,
    input  t_year   i_year,
    output t_serial o_serial,
    output logic    o_bad
);

    logic        div4;
    logic [8:0]  cent;
    logic        div100;
    logic        div400;
    logic        leap;
    logic [14:0] yp3;
    logic [14:0] yp99;
    logic [14:0] yp399;
    logic [12:0] leaps;
    logic [12:0] n4;
    logic [8:0]  n100;
    logic [8:0]  n400;
    t_serial     base;
    logic        mon_ok;
    t_day        len;
    logic        day_ok;
    logic [8:0]  doy;

    // Leap year test: y/100 = floor(floor(y/4)/25)
    always_comb begin
        div4   = (i_year[1:0] == 2'd0);
        cent   = div25({1'b0, i_year[YearW-1:2]});
        div100 = div4 && ({1'b0, i_year[YearW-1:2]} == 13'(cent) * 13'd25);
        div400 = div100 && (cent[1:0] == 2'd0);
        leap   = div4 && (!div100 || div400);
    end

    // Leap years in [0, y): ceil(y/4) - ceil(y/100) + ceil(y/400)
    always_comb begin
        yp3   = 15'(i_year) + 15'd3;
        yp99  = 15'(i_year) + 15'd99;
        yp399 = 15'(i_year) + 15'd399;
        n4    = yp3[14:2];
        n100  = div25(yp99[14:2]);
        n400  = div25(13'(yp399[14:4]));
        leaps = n4 - 13'(n100) + 13'(n400);
        base  = SerialW'(i_year) * SerialW'(365);
    end

    // Day of year; an invalid date contributes zero
    always_comb begin
        mon_ok = (i_month >= MonJan) && (i_month <= MonDec);
        len    = month_len(i_month);
        if (i_month == MonFeb && leap) begin
            len = 5'd29;
        end
        day_ok = mon_ok && (i_day != 5'd0) && (i_day <= len);
        doy    = 9'd0;
        if (day_ok) begin
            doy = days_before(i_month) + 9'(i_day) + 9'(i_month > MonFeb && leap);
        end
        o_bad    = !day_ok;
        o_serial = base + SerialW'(leaps) + SerialW'(doy);
    end

endmodule

[hdl/days_between_dates_core.sv]
`timescale 1ns / 1ps
// Days between two Gregorian dates.
// Input: a date pair (day, month, year for each) on the i_ ports, transferred
//   at a rising edge where start is high and busy is low. busy is always low,
//   so a new pair may be transferred every cycle.
// Output: o_day_difference (second minus first, in days, saturated to
//   +/-3660000) and o_date_invalid (either date impossible; that date then
//   counts as day-of-year 0), marked by o_valid for exactly one cycle.
// Pipeline: the pair is captured in an input register; one pass of
//   serial-day logic for both dates plus a subtract and clamp feeds the result
//   register, which drives o_valid and the result outputs.
// Throughput: one pair per cycle, set by the single register-to-register pass.
// Reset: synchronous, active low; clears the valid flags of both stages, so
//   no result is shown after reset until a new transfer.
// The receiver cannot stall: each result is present for one cycle only.
`include "assert_macros.svh"

module days_between_dates_core
    import dbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_day               i_first_day,
    input  t_month             i_first_month,
    input  t_year              i_first_year,
    input  t_day               i_second_day,
    input  t_month             i_second_month,
    input  t_year              i_second_year,
    output logic               o_valid,
    output logic signed [DiffW-1:0] o_day_difference,
    output logic               o_date_invalid
);

    logic   r_in_valid;
    t_day   r_d1, r_d2;
    t_month r_m1, r_m2;
    t_year  r_y1, r_y2;

    t_serial s1, s2;
    logic    bad1, bad2;
    logic signed [SerialW:0] diff;
    logic signed [DiffW-1:0] n_diff;

    logic                    r_valid;
    logic signed [DiffW-1:0] r_diff;
    logic                    r_invalid;

    assign busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_d1 <= i_first_day;
            r_m1 <= i_first_month;
            r_y1 <= i_first_year;
            r_d2 <= i_second_day;
            r_m2 <= i_second_month;
            r_y2 <= i_second_year;
        end
    end

    dbd_serial u_first (
        .i_day    (r_d1),
        .i_month  (r_m1),
        .i_year   (r_y1),
        .o_serial (s1),
        .o_bad    (bad1)
    );

    dbd_serial u_second (
        .i_day    (r_d2),
        .i_month  (r_m2),
        .i_year   (r_y2),
        .o_serial (s2),
        .o_bad    (bad2)
    );

    // Difference and clamp
    always_comb begin
        diff = $signed({1'b0, s2}) - $signed({1'b0, s1});
        if (diff > (SerialW+1)'(DiffLimit)) begin
            n_diff = DiffW'(DiffLimit);
        end else if (diff < -(SerialW+1)'(DiffLimit)) begin
            n_diff = -DiffW'(DiffLimit);
        end else begin
            n_diff = diff[DiffW-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_diff    <= n_diff;
            r_invalid <= bad1 || bad2;
        end
    end

    assign o_valid          = r_valid;
    assign o_day_difference = r_diff;
    assign o_date_invalid   = r_invalid;

    // Checks
    `DBD_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, r_in_valid, o_valid)
    `DBD_ASSERT_IMP(a_diff_clamped, i_clk, i_rst_n, o_valid, o_day_difference <= DiffW'(DiffLimit) && o_day_difference >= -DiffW'(DiffLimit))
    `DBD_ASSERT_NXT(a_same_date_zero, i_clk, i_rst_n, r_in_valid && r_d1 == r_d2 && r_m1 == r_m2 && r_y1 == r_y2, o_day_difference == '0)

endmodule

[dv/tb_days_between_dates_core.sv]
`timescale 1ns / 1ps

module tb_days_between_dates_core;
    import dbd_pkg::*;

    localparam int RandomPairs = 1750;
    localparam int CycleLimit  = 250000;
    localparam int DrainCycles = 10;

    // Month values used by the directed pairs
    localparam t_month MonNone = 4'd0;
    localparam t_month MonMar  = 4'd3;
    localparam t_month MonApr  = 4'd4;
    localparam t_month MonOver = 4'd13;
    localparam t_month MonTop  = 4'd15;

    // One expected result
    typedef struct {
        logic signed [DiffW-1:0] days;
        logic                    bad;
    } t_gap;

    // Date-difference predictor and store of pending results
    class date_gap_scoreboard;
        t_gap        pending_q[$];
        int unsigned mismatch_count;
        int unsigned common_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

        function bit is_leap(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        // Leap years in [0, y), year 0 included
        function int unsigned leap_days_upto(int unsigned y);
            return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        // Zero for an impossible month
        function int unsigned month_length(t_month m, t_year y);
            int unsigned len;
            if (m < MonJan || m > MonDec)
                return 0;
            len = common_len[m - 1];
            if (m == MonFeb && is_leap(y))
                len = 29;
            return len;
        endfunction

        // Serial day number; impossible date counts as day-of-year 0
        function longint day_serial(t_day d, t_month m, t_year y, inout bit bad);
            int unsigned len;
            int unsigned doy;
            int          k;
            doy = 0;
            len = month_length(m, y);
            if (len != 0 && d >= 1 && d <= len) begin
                for (k = 1; k < int'(m); k++)
                    doy += common_len[k - 1];
                doy += d;
                if (m > MonFeb && is_leap(y))
                    doy += 1;
            end else begin
                bad = 1'b1;
            end
            return 64'sd365 * longint'(y) + longint'(leap_days_upto(y)) + longint'(doy);
        endfunction

        // Accepted transfer: predict its result
        function void note_pair(t_day d1, t_month m1, t_year y1,
                                t_day d2, t_month m2, t_year y2);
            t_gap   want;
            bit     bad;
            longint diff;
            bad  = 1'b0;
            diff = day_serial(d2, m2, y2, bad) - day_serial(d1, m1, y1, bad);
            if (diff > DiffLimit)
                diff = DiffLimit;
            if (diff < -DiffLimit)
                diff = -DiffLimit;
            want.days = diff[DiffW-1:0];
            want.bad  = bad;
            pending_q.insert(pending_q.size(), want);
        endfunction

        // Result strobe seen: compare with oldest prediction
        function void check_result(logic signed [DiffW-1:0] days, logic bad);
            t_gap want;
            if (pending_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result days=%0d invalid=%b", days, bad);
                return;
            end
            want = pending_q.pop_front();
            if (days !== want.days || bad !== want.bad) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: days exp=%0d got=%0d, invalid exp=%b got=%b",
                             want.days, days, want.bad, bad);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    t_day                    i_first_day;
    t_month                  i_first_month;
    t_year                   i_first_year;
    t_day                    i_second_day;
    t_month                  i_second_month;
    t_year                   i_second_year;
    logic                    o_valid;
    logic signed [DiffW-1:0] o_day_difference;
    logic                    o_date_invalid;

    date_gap_scoreboard sb;
    int unsigned        cycle_count;
    int                 calm_left;

    days_between_dates_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_day      (i_first_day),
        .i_first_month    (i_first_month),
        .i_first_year     (i_first_year),
        .i_second_day     (i_second_day),
        .i_second_month   (i_second_month),
        .i_second_year    (i_second_year),
        .o_valid          (o_valid),
        .o_day_difference (o_day_difference),
        .o_date_invalid   (o_date_invalid)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_day_difference, o_date_invalid);
    end

    // Idle cycles after a transfer: mostly none, sometimes a run of back-to-back transfers
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Drive one date pair and wait for its transfer
    task automatic send_pair(t_day d1, t_month m1, t_year y1,
                             t_day d2, t_month m2, t_year y2);
        int gap;
        @(negedge i_clk);
        start          = 1'b1;
        i_first_day    = d1;
        i_first_month  = m1;
        i_first_year   = y1;
        i_second_day   = d2;
        i_second_month = m2;
        i_second_year  = y2;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.note_pair(d1, m1, y1, d2, m2, y2);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Mostly 4-digit years, some centuries and some beyond 9999
    function automatic t_year pick_year();
        case ($urandom_range(0, 9))
            0:       return t_year'($urandom_range(0, 163) * 100);
            1:       return t_year'($urandom_range(10000, 16383));
            default: return t_year'($urandom_range(0, 9999));
        endcase
    endfunction

    task automatic send_random_pair();
        t_day   d1, d2;
        t_month m1, m2;
        t_year  y1, y2;
        int     kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // Two well-formed dates, sometimes close together
            y1 = pick_year();
            if ($urandom_range(0, 4) == 0)
                y2 = t_year'(int'(y1) + $urandom_range(0, 4) - 2);
            else
                y2 = pick_year();
            m1 = t_month'($urandom_range(1, 12));
            m2 = t_month'($urandom_range(1, 12));
            d1 = t_day'($urandom_range(1, sb.month_length(m1, y1)));
            d2 = t_day'($urandom_range(1, sb.month_length(m2, y2)));
        end else if (kind < 85) begin
            // Around the end of February, leap and century years
            y1 = t_year'($urandom_range(0, 4095) * 4);
            y2 = ($urandom_range(0, 1) == 1) ? y1 : t_year'(int'(y1) + 1);
            m1 = MonFeb;
            d1 = t_day'($urandom_range(27, 30));
            m2 = ($urandom_range(0, 1) == 1) ? MonFeb : MonMar;
            d2 = t_day'($urandom_range(1, 29));
        end else begin
            // Raw field values
            d1 = t_day'($urandom);
            m1 = t_month'($urandom);
            y1 = t_year'($urandom);
            d2 = t_day'($urandom);
            m2 = t_month'($urandom);
            y2 = t_year'($urandom);
        end
        send_pair(d1, m1, y1, d2, m2, y2);
    endtask

    initial begin
        sb             = new();
        cycle_count    = 0;
        calm_left      = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_first_day    = '0;
        i_first_month  = '0;
        i_first_year   = '0;
        i_second_day   = '0;
        i_second_month = '0;
        i_second_year  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, leap rules, impossible dates, saturation
        send_pair(5'd1, MonJan, 14'd0, 5'd1, MonJan, 14'd0);
        send_pair(5'd1, MonJan, 14'd0, 5'd31, MonDec, 14'd9999);
        send_pair(5'd31, MonDec, 14'd9999, 5'd1, MonJan, 14'd0);
        send_pair(5'd28, MonFeb, 14'd2000, 5'd29, MonFeb, 14'd2000);
        send_pair(5'd29, MonFeb, 14'd1900, 5'd1, MonMar, 14'd1900);
        send_pair(5'd29, MonFeb, 14'd2004, 5'd1, MonMar, 14'd2004);
        send_pair(5'd29, MonFeb, 14'd2001, 5'd1, MonMar, 14'd2001);
        send_pair(5'd28, MonFeb, 14'd2001, 5'd1, MonMar, 14'd2001);
        send_pair(5'd29, MonFeb, 14'd0, 5'd1, MonMar, 14'd0);
        send_pair(5'd10, MonNone, 14'd2020, 5'd10, MonJan, 14'd2020);
        send_pair(5'd10, MonJan, 14'd2020, 5'd10, MonOver, 14'd2020);
        send_pair(5'd31, MonTop, 14'd16383, 5'd31, MonTop, 14'd16383);
        send_pair(5'd0, MonMar, 14'd1999, 5'd1, MonMar, 14'd1999);
        send_pair(5'd31, MonApr, 14'd1999, 5'd30, MonApr, 14'd1999);
        send_pair(5'd31, MonDec, 14'd1999, 5'd1, MonJan, 14'd2000);
        send_pair(5'd1, MonJan, 14'd0, 5'd31, MonDec, 14'd16383);
        send_pair(5'd31, MonDec, 14'd16383, 5'd1, MonJan, 14'd0);
        send_pair(5'd1, MonJan, 14'd10000, 5'd1, MonJan, 14'd16383);
        send_pair(5'd1, MonJan, 14'd0, 5'd1, MonJan, 14'd10027);
        send_pair(5'd1, MonJan, 14'd100, 5'd1, MonJan, 14'd400);
        send_pair(5'd0, MonNone, 14'd0, 5'd0, MonNone, 14'd0);

        repeat (RandomPairs) send_random_pair();

        @(negedge i_clk);
        start = 1'b0;

        // Drain outstanding results, then settle
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
